/* rtl/fltw_pkg.sv */
// shared types and constants of the four-level translation table walker
package fltw_pkg;

  localparam int unsigned ADDR_W  = 48;
  localparam int unsigned IDX_W   = 9;
  localparam int unsigned OFF_W   = 12;
  localparam int unsigned FRAME_W = ADDR_W - OFF_W;
  localparam int unsigned USED_W  = 7;

  localparam logic [2:0]       ENTRY_RWX = 3'b111;
  localparam logic [2:0]       MT_WB     = 3'd6;
  localparam logic [OFF_W-1:0] PTR_ATTR  = {9'd0, ENTRY_RWX};
  localparam logic [OFF_W-1:0] LEAF_ATTR = {6'd0, MT_WB, ENTRY_RWX};

  typedef enum logic [1:0] {
    OP_MAP   = 2'd0,
    OP_UNMAP = 2'd1,
    OP_XLATE = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_MISSING  = 3'd1,
    ST_NO_PAGE  = 3'd2,
    ST_MAPPED   = 3'd3,
    ST_UNMAPPED = 3'd4
  } status_e;

  typedef struct packed {
    logic    clr;
    logic    load;
    logic    adv;
    logic    alloc;
    logic    wr_leaf;
    logic    set_st;
    status_e st;
    logic    set_res;
    logic    done;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    op_e  op;
    logic create;
    logic overwrite;
    logic report;
    logic present;
    logic child_bad;
    logic at_leaf;
    logic no_page;
    logic out_busy;
  } stat_t;

endpackage

/* rtl/fltw_if.sv */
// request and response channel interfaces of the walker
interface fltw_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [47:0] guest_addr;
  logic [47:0] host_addr;
  logic        create_missing;
  logic        allow_overwrite;
  logic        report_unmapped;

  modport source (
    output valid, operation, guest_addr, host_addr, create_missing, allow_overwrite,
           report_unmapped,
    input  ready
  );
  modport sink (
    input  valid, operation, guest_addr, host_addr, create_missing, allow_overwrite,
           report_unmapped,
    output ready
  );
endinterface

interface fltw_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [47:0] result_addr;
  logic [6:0]  tables_used;

  modport source (
    output valid, status, result_addr, tables_used,
    input  ready
  );
  modport sink (
    input  valid, status, result_addr, tables_used,
    output ready
  );
endinterface

/* rtl/fltw_ram.sv */
// generic single-port ram with registered read
module fltw_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 512,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/fltw_ctrl.sv */
// walk controller state machine
module fltw_ctrl import fltw_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  req_valid_i,
  output logic  req_ready_o,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_READ  = 5'b00100,
    S_EVAL  = 5'b01000,
    S_FIN   = 5'b10000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    req_ready_o = 1'b0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clr = 1'b1;
        if (stat_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_READ;
        end
      end
      S_READ: begin
        if (stat_i.op == OP_NONE) begin
          state_d = S_FIN;
        end else begin
          state_d = S_EVAL;
        end
      end
      S_EVAL: begin
        state_d = S_FIN;
        if (stat_i.at_leaf) begin
          case (stat_i.op)
            OP_MAP: begin
              if (stat_i.present && !stat_i.overwrite) begin
                cmd_o.set_st = 1'b1;
                cmd_o.st     = ST_MAPPED;
              end else begin
                cmd_o.wr_leaf = 1'b1;
              end
            end
            OP_UNMAP: begin
              cmd_o.wr_leaf = 1'b1;
            end
            OP_XLATE: begin
              if (!stat_i.present && stat_i.report) begin
                cmd_o.set_st = 1'b1;
                cmd_o.st     = ST_UNMAPPED;
              end else begin
                cmd_o.set_res = 1'b1;
              end
            end
            default: ;
          endcase
        end else if (stat_i.present) begin
          if (stat_i.child_bad) begin
            cmd_o.set_st = 1'b1;
            cmd_o.st     = ST_MISSING;
          end else begin
            cmd_o.adv = 1'b1;
            state_d   = S_READ;
          end
        end else if (!(stat_i.op == OP_MAP && stat_i.create)) begin
          cmd_o.set_st = 1'b1;
          cmd_o.st     = ST_MISSING;
        end else if (stat_i.no_page) begin
          cmd_o.set_st = 1'b1;
          cmd_o.st     = ST_NO_PAGE;
        end else begin
          cmd_o.alloc = 1'b1;
          state_d     = S_READ;
        end
      end
      S_FIN: begin
        if (!stat_i.out_busy) begin
          cmd_o.done = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* rtl/fltw_dp.sv */
// walk datapath: request capture, walk pointer, allocator, clear counter, result beat
module fltw_dp import fltw_pkg::*; #(
  parameter int unsigned TABLE_PAGES = 64,
  parameter int unsigned WALK_LEVELS = 4,
  parameter int unsigned MEM_DEPTH   = TABLE_PAGES * (2 ** IDX_W),
  parameter int unsigned MEM_AW      = $clog2(MEM_DEPTH)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cmd_t              cmd_i,
  output stat_t             stat_o,
  fltw_req_if.sink          req_i,
  fltw_rsp_if.source        rsp_o,
  output logic              mem_we_o,
  output logic [MEM_AW-1:0] mem_addr_o,
  output logic [ADDR_W-1:0] mem_wdata_o,
  input  logic [ADDR_W-1:0] mem_rdata_i
);

  localparam int unsigned PAGE_W = (TABLE_PAGES > 1) ? $clog2(TABLE_PAGES) : 1;
  localparam int unsigned CNT_W  = $clog2(TABLE_PAGES + 1);
  localparam int unsigned LVL_W  = (WALK_LEVELS > 1) ? $clog2(WALK_LEVELS) : 1;

  logic [ADDR_W-1:0] ga_q;
  logic [ADDR_W-1:0] ha_q;
  op_e               op_q;
  logic              create_q;
  logic              overwrite_q;
  logic              report_q;
  logic [PAGE_W-1:0] page_q;
  logic [LVL_W-1:0]  lvl_q;
  logic [CNT_W-1:0]  nfp_q;
  logic [MEM_AW-1:0] clr_q;
  status_e           st_q;
  logic [ADDR_W-1:0] res_q;

  logic              out_valid_q;
  status_e           out_st_q;
  logic [ADDR_W-1:0] out_res_q;
  logic [USED_W-1:0] out_used_q;

  logic [ADDR_W-1:0]       ga_sh;
  logic [IDX_W-1:0]        idx;
  logic [PAGE_W+IDX_W-1:0] walk_addr;
  logic [FRAME_W-1:0]      child;
  logic [CNT_W+USED_W-1:0] used_ext;

  assign ga_sh     = ga_q >> (OFF_W + IDX_W * (WALK_LEVELS - 1 - int'(lvl_q)));
  assign idx       = ga_sh[IDX_W-1:0];
  assign walk_addr = {page_q, idx};
  assign child     = mem_rdata_i[ADDR_W-1:OFF_W];
  assign used_ext  = {{USED_W{1'b0}}, nfp_q};

  assign mem_we_o   = cmd_i.clr | cmd_i.alloc | cmd_i.wr_leaf;
  assign mem_addr_o = cmd_i.clr ? clr_q : walk_addr[MEM_AW-1:0];

  always_comb begin
    mem_wdata_o = '0;
    if (cmd_i.alloc) begin
      mem_wdata_o = {FRAME_W'(nfp_q), PTR_ATTR};
    end else if (cmd_i.wr_leaf && op_q == OP_MAP) begin
      mem_wdata_o = {ha_q[ADDR_W-1:OFF_W], LEAF_ATTR};
    end
  end

  assign stat_o.clr_last  = (clr_q == MEM_AW'(MEM_DEPTH - 1));
  assign stat_o.op        = op_q;
  assign stat_o.create    = create_q;
  assign stat_o.overwrite = overwrite_q;
  assign stat_o.report    = report_q;
  assign stat_o.present   = |mem_rdata_i[2:0];
  assign stat_o.child_bad = (child >= FRAME_W'(TABLE_PAGES));
  assign stat_o.at_leaf   = (lvl_q == LVL_W'(WALK_LEVELS - 1));
  assign stat_o.no_page   = (nfp_q >= CNT_W'(TABLE_PAGES));
  assign stat_o.out_busy  = out_valid_q & ~rsp_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nfp_q       <= CNT_W'(1);
      clr_q       <= '0;
      page_q      <= '0;
      lvl_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clr) begin
        clr_q <= clr_q + MEM_AW'(1);
      end
      if (cmd_i.load) begin
        page_q <= '0;
        lvl_q  <= '0;
      end else if (cmd_i.adv) begin
        page_q <= child[PAGE_W-1:0];
        lvl_q  <= lvl_q + LVL_W'(1);
      end else if (cmd_i.alloc) begin
        page_q <= nfp_q[PAGE_W-1:0];
        lvl_q  <= lvl_q + LVL_W'(1);
      end
      if (cmd_i.alloc) begin
        nfp_q <= nfp_q + CNT_W'(1);
      end
      if (cmd_i.done) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      ga_q        <= req_i.guest_addr;
      ha_q        <= req_i.host_addr;
      op_q        <= op_e'(req_i.operation);
      create_q    <= req_i.create_missing;
      overwrite_q <= req_i.allow_overwrite;
      report_q    <= req_i.report_unmapped;
      st_q        <= ST_OK;
      res_q       <= '0;
    end else begin
      if (cmd_i.set_st) begin
        st_q <= cmd_i.st;
      end
      if (cmd_i.set_res) begin
        res_q <= {mem_rdata_i[ADDR_W-1:OFF_W], ga_q[OFF_W-1:0]};
      end
    end
    if (cmd_i.done) begin
      out_st_q   <= st_q;
      out_res_q  <= res_q;
      out_used_q <= used_ext[USED_W-1:0];
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.status      = out_st_q;
  assign rsp_o.result_addr = out_res_q;
  assign rsp_o.tables_used = out_used_q;

endmodule

/* rtl/four_level_translation_table_walker_top.sv */
// top level of the four-level translation table walker
// a walk visits each level with a table read, then an evaluate and write step
// the next request is taken only after the walk has ended, and a walk waits to end
// while an earlier result beat is still pending; operation 3 skips the walk
// after reset a clearing pass zeroes all TABLE_PAGES * 512 entries of the table store
// (32768 by default), with the request channel not ready
module four_level_translation_table_walker_top import fltw_pkg::*; #(
  parameter int unsigned TABLE_PAGES = 64,
  parameter int unsigned WALK_LEVELS = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  fltw_req_if.sink   req_i,
  fltw_rsp_if.source rsp_o
);

  localparam int unsigned MEM_DEPTH = TABLE_PAGES * (2 ** IDX_W);
  localparam int unsigned MEM_AW    = $clog2(MEM_DEPTH);

  cmd_t              cmd;
  stat_t             stat;
  logic              req_ready;
  logic              mem_we;
  logic [MEM_AW-1:0] mem_addr;
  logic [ADDR_W-1:0] mem_wdata;
  logic [ADDR_W-1:0] mem_rdata;

  assign req_i.ready = req_ready;

  fltw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  fltw_dp #(
    .TABLE_PAGES (TABLE_PAGES),
    .WALK_LEVELS (WALK_LEVELS),
    .MEM_DEPTH   (MEM_DEPTH),
    .MEM_AW      (MEM_AW)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .req_i       (req_i),
    .rsp_o       (rsp_o),
    .mem_we_o    (mem_we),
    .mem_addr_o  (mem_addr),
    .mem_wdata_o (mem_wdata),
    .mem_rdata_i (mem_rdata)
  );

  fltw_ram #(
    .WIDTH (ADDR_W),
    .DEPTH (MEM_DEPTH),
    .AW    (MEM_AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

`ifndef SYNTHESIS
  a_alloc_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.alloc |-> !stat.no_page)
    else $error("table page allocated beyond the store");

  a_one_writer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.clr, cmd.alloc, cmd.wr_leaf}))
    else $error("more than one table store write source");

  a_done_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.done |-> !stat.out_busy)
    else $error("result beat loaded over a pending beat");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> !req_i.ready)
    else $error("request taken while a walk is running");
`endif

endmodule
